[rtl/encvel_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encvel_pkg
// shared types and constants of the two-channel encoder speed meter
// ----------------------------------------------------------------------------
package encvel_pkg;

  // operation codes of an input beat
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_POLE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_INPUT_GAIN = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [15:0] CPR_RESET  = 16'd1020;
  localparam logic [14:0] POLE_RESET = 15'd27984;
  localparam logic [14:0] GAIN_RESET = 15'd2385;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CPR_W  = 16;
  localparam int unsigned COEF_W = 15;
  localparam int unsigned DEN_W  = TIME_W + CPR_W;

  // 60 s * 1e6 us * 256 (q.8) = 234375 * 2^16
  localparam int unsigned SCALE_BITS  = 18;
  localparam int unsigned SCALE_IDX_W = 5;
  localparam int unsigned SCALE_SHIFT = 16;
  localparam logic [SCALE_BITS-1:0] SCALE_MULT = 18'd234375;

  // filter rounding: half of 2^15
  localparam int unsigned FILT_SHIFT = 15;
  localparam int unsigned FILT_ROUND = 16384;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DEN  = 9'b000000010,
    ST_MAG  = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_RAW  = 9'b000100000,
    ST_FILT = 9'b001000000,
    ST_FWB  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

[rtl/encoder_velocity_estimator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_velocity_estimator_unit
// two-channel quadrature speed meter: position counters, scaled speed by
// restoring division and a first-order iir low-pass per channel
// ----------------------------------------------------------------------------
// sequence: an edge beat updates its position counter as it is taken; a sample beat
//   registers the timestamp and forms the denominator, then per channel the magnitude,
//   18 shift-add steps of the scale multiply, SPEED_WIDTH+1 steps of the shared
//   subtractor, the filter mac steps and the write-back, then the output register
// input: one edge per cycle while idle; no beat is taken until a sample's result
//   is in the output register, later while a held result beat keeps it full
// reset: counters, filter state and timestamp clear; registers take defaults
// ----------------------------------------------------------------------------
module encoder_velocity_estimator_unit #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned SPEED_WIDTH = 24
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration write port
  input  wire                                 cfg_we_i,
  input  wire  [encvel_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [encvel_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire                                 operation_i,
  input  wire                                 channel_i,
  input  wire                                 b_level_i,
  input  wire  [encvel_pkg::TIME_W-1:0]       time_us_i,
  // result channel
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic signed [SPEED_WIDTH-1:0]       speed_first_o,
  output logic signed [SPEED_WIDTH-1:0]       speed_second_o,
  output logic                                zero_interval_o
);
  import encvel_pkg::*;

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned SW    = SPEED_WIDTH;
  // numerator is mag * 234375 * 2^16
  localparam int unsigned NUM_W = CW + SCALE_BITS + SCALE_SHIFT;
  // divisor starts at den << SW
  localparam int unsigned DV_W  = DEN_W + SW;
  localparam int unsigned REM_W = (NUM_W > DV_W) ? NUM_W : DV_W;
  localparam int unsigned CNT_MAX = (SW > SCALE_BITS) ? SW : SCALE_BITS;
  localparam int unsigned CNT_W = $clog2(CNT_MAX + 1);
  localparam int unsigned ACC_W = SW + 18;
  localparam int unsigned PROD_W = SW + 16;

  // quotient threshold 2^(SW-1), as a SW+1 bit value
  localparam logic [SW:0] HALF_Q = {2'b01, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] RAW_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] RAW_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI = {{19{1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{19{1'b1}}, {(SW-1){1'b0}}};

  // configuration registers
  logic [CPR_W-1:0]  cpr_q;
  logic [COEF_W-1:0] pole_q;
  logic [COEF_W-1:0] gain_q;

  // control and architectural state
  state_e               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 ch_q, ch_d;
  logic [CW-1:0]        pos_q [2];
  logic [CW-1:0]        pos_d [2];
  logic [CW-1:0]        samp_q [2];
  logic [CW-1:0]        samp_d [2];
  logic signed [SW-1:0] filt_q [2];
  logic signed [SW-1:0] filt_d [2];
  logic signed [SW-1:0] prev_q [2];
  logic signed [SW-1:0] prev_d [2];
  logic [TIME_W-1:0]    last_time_q, last_time_d;

  // datapath registers
  logic [TIME_W-1:0]     time_q, time_d;
  logic                  zero_q, zero_d;
  logic [DEN_W-1:0]      den_q, den_d;
  logic                  neg_q, neg_d;
  logic [CW-1:0]         mag_q, mag_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [REM_W-1:0]      dv_q, dv_d;
  logic [SW:0]           quo_q, quo_d;
  logic signed [SW-1:0]  raw_q, raw_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [SW-1:0]  spd0_q, spd0_d;
  logic signed [SW-1:0]  spd1_q, spd1_d;
  logic                  zflag_q, zflag_d;

  logic                  in_take;

  assign in_stall_o      = (state_q != ST_IDLE);
  assign in_take         = in_valid_i && !in_stall_o;
  assign out_valid_o     = out_valid_q;
  assign speed_first_o   = spd0_q;
  assign speed_second_o  = spd1_q;
  assign zero_interval_o = zflag_q;

  always_comb begin
    logic [TIME_W-1:0]       dt;
    logic [CPR_W-1:0]        cpr_eff;
    logic [CW-1:0]           delta;
    logic [REM_W-1:0]        mul_sum;
    logic [REM_W:0]          diff;
    logic                    ge;
    logic signed [SW-1:0]    mul_a;
    logic signed [15:0]      mul_b;
    logic signed [ACC_W-1:0] sh;
    logic signed [SW-1:0]    y;

    state_d     = state_q;
    out_valid_d = out_valid_q;
    ch_d        = ch_q;
    pos_d       = pos_q;
    samp_d      = samp_q;
    filt_d      = filt_q;
    prev_d      = prev_q;
    last_time_d = last_time_q;
    time_d      = time_q;
    zero_d      = zero_q;
    den_d       = den_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    dv_d        = dv_q;
    quo_d       = quo_q;
    raw_d       = raw_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    spd0_d      = spd0_q;
    spd1_d      = spd1_q;
    zflag_d     = zflag_q;

    dt      = time_q - last_time_q;
    cpr_eff = (cpr_q == '0) ? CPR_W'(1) : cpr_q;
    delta   = pos_q[ch_q] - samp_q[ch_q];
    mul_sum = (rem_q << 1) + (SCALE_MULT[cnt_q[SCALE_IDX_W-1:0]] ? REM_W'(mag_q) : '0);
    diff    = {1'b0, rem_q} - {1'b0, dv_q};
    ge      = !diff[REM_W];
    sh      = acc_q >>> FILT_SHIFT;

    // operand select of the shared filter multiplier
    unique case (cnt_q[1:0])
      2'd0: begin
        mul_a = filt_q[ch_q];
        mul_b = $signed({1'b0, pole_q});
      end
      2'd1: begin
        mul_a = raw_q;
        mul_b = $signed({1'b0, gain_q});
      end
      default: begin
        mul_a = prev_q[ch_q];
        mul_b = $signed({1'b0, gain_q});
      end
    endcase

    // saturate the rounded filter output
    if (sh > SAT_HI) begin
      y = RAW_MAX;
    end else if (sh < SAT_LO) begin
      y = RAW_MIN;
    end else begin
      y = sh[SW-1:0];
    end

    // result leaves the output register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (operation_i == OP_SAMPLE) begin
            time_d  = time_us_i;
            state_d = ST_DEN;
          end else if (b_level_i) begin
            pos_d[channel_i] = pos_q[channel_i] - CW'(1);
          end else begin
            pos_d[channel_i] = pos_q[channel_i] + CW'(1);
          end
        end
      end
      ST_DEN: begin
        zero_d  = (dt == '0);
        den_d   = dt * cpr_eff;
        ch_d    = 1'b0;
        state_d = ST_MAG;
      end
      ST_MAG: begin
        neg_d   = delta[CW-1];
        mag_d   = delta[CW-1] ? (~delta + CW'(1)) : delta;
        rem_d   = '0;
        cnt_d   = CNT_W'(SCALE_BITS - 1);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // msb-first shift-add by the scale constant
        if (cnt_q == '0) begin
          rem_d   = mul_sum << SCALE_SHIFT;
          dv_d    = REM_W'(den_q) << SW;
          quo_d   = '0;
          cnt_d   = CNT_W'(SW);
          state_d = ST_DIV;
        end else begin
          rem_d = mul_sum;
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (ge) begin
          rem_d = diff[REM_W-1:0];
        end
        quo_d = {quo_q[SW-1:0], ge};
        dv_d  = dv_q >> 1;
        if (cnt_q == '0) begin
          state_d = ST_RAW;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_RAW: begin
        if (zero_q) begin
          raw_d = '0;
        end else if (neg_q) begin
          raw_d = (quo_q >= HALF_Q) ? RAW_MIN : $signed(~quo_q[SW-1:0] + SW'(1));
        end else begin
          raw_d = (quo_q >= HALF_Q) ? RAW_MAX : $signed(quo_q[SW-1:0]);
        end
        acc_d   = ACC_W'(FILT_ROUND);
        cnt_d   = '0;
        state_d = ST_FILT;
      end
      ST_FILT: begin
        // product of term k registered, added in the next cycle unless it is the last term
        prod_d = mul_a * mul_b;
        if (cnt_q != '0) begin
          acc_d = acc_q + ACC_W'(prod_q);
        end
        if (cnt_q == CNT_W'(3)) begin
          state_d = ST_FWB;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_FWB: begin
        filt_d[ch_q] = y;
        prev_d[ch_q] = raw_q;
        samp_d[ch_q] = pos_q[ch_q];
        if (!ch_q) begin
          ch_d    = 1'b1;
          state_d = ST_MAG;
        end else begin
          last_time_d = time_q;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for a free output register
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          spd0_d      = filt_q[0];
          spd1_d      = filt_q[1];
          zflag_d     = zero_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= 1'b0;
      pos_q       <= '{default: '0};
      samp_q      <= '{default: '0};
      filt_q      <= '{default: '0};
      prev_q      <= '{default: '0};
      last_time_q <= '0;
      cpr_q       <= CPR_RESET;
      pole_q      <= POLE_RESET;
      gain_q      <= GAIN_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ch_q        <= ch_d;
      pos_q       <= pos_d;
      samp_q      <= samp_d;
      filt_q      <= filt_d;
      prev_q      <= prev_d;
      last_time_q <= last_time_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_COUNTS_PER_REV:    cpr_q  <= cfg_data_i;
          CFG_FILTER_POLE:       pole_q <= cfg_data_i[COEF_W-1:0];
          CFG_FILTER_INPUT_GAIN: gain_q <= cfg_data_i[COEF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    time_q  <= time_d;
    zero_q  <= zero_d;
    den_q   <= den_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    rem_q   <= rem_d;
    dv_q    <= dv_d;
    quo_q   <= quo_d;
    raw_q   <= raw_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    cnt_q   <= cnt_d;
    spd0_q  <= spd0_d;
    spd1_q  <= spd1_d;
    zflag_q <= zflag_d;
  end

endmodule
`default_nettype wire

[rtl/encvel_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encvel_checker
// port-level checks of the encoder speed meter, bound to the top level
// ----------------------------------------------------------------------------
module encvel_checker #(
  parameter int unsigned SPEED_WIDTH = 24
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_valid_i,
  input wire                   in_stall_i,
  input wire                   operation_i,
  input wire                   out_valid_i,
  input wire                   out_stall_i,
  input wire [SPEED_WIDTH-1:0] speed_first_i,
  input wire [SPEED_WIDTH-1:0] speed_second_i,
  input wire                   zero_interval_i
);
  import encvel_pkg::*;

  // a pending result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a pending result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=>
      $stable(speed_first_i) && $stable(speed_second_i) && $stable(zero_interval_i))
    else $error("result payload changed while stalled");

  // a sample beat occupies the sequencer
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && (operation_i == OP_SAMPLE) |=> in_stall_i)
    else $error("input taken right after a sample beat");

  // an edge beat leaves the input ready for the next beat
  a_edge_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && (operation_i != OP_SAMPLE) |=> !in_stall_i)
    else $error("input stalled after an edge beat");

endmodule

bind encoder_velocity_estimator_unit encvel_checker #(
  .SPEED_WIDTH(SPEED_WIDTH)
) u_encvel_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_i     (in_stall_o),
  .operation_i    (operation_i),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .speed_first_i  (speed_first_o),
  .speed_second_i (speed_second_o),
  .zero_interval_i(zero_interval_o)
);
`default_nettype wire
